FILE: rtl/core/wifi_channel_interference_select_assert.svh
// Assertion macros for the interference-based channel selector.
`ifndef WIFI_CHANNEL_INTERFERENCE_SELECT_ASSERT_SVH
`define WIFI_CHANNEL_INTERFERENCE_SELECT_ASSERT_SVH
`ifndef SYNTH
`define WCIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define WCIS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define WCIS_ASSERT(lbl, prop, msg)
`define WCIS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: rtl/core/wcis_pkg.sv
// Types, constants and helper functions shared by the channel selector modules.
`default_nettype none
package wcis_pkg;

  localparam int unsigned NUM_CAND = 3;
  localparam int unsigned CH_W     = 8;
  localparam int unsigned OUT_W    = 4;
  localparam int unsigned STR_W    = 7;
  localparam int unsigned SQ_W     = 13;
  localparam int unsigned WGT_W    = 3;
  localparam int unsigned PROD_W   = SQ_W + WGT_W;
  localparam int unsigned SCORE_W  = 64;
  localparam int unsigned IDX_W    = 2;

  localparam logic [OUT_W-1:0] CAND_CH [NUM_CAND] = '{4'd1, 4'd6, 4'd11};

  localparam logic [CH_W-1:0]  PREF_RESET   = 8'd1;
  localparam logic [CH_W-1:0]  MAX_CHANNEL  = 8'd14;
  localparam logic [CH_W-1:0]  MAX_DISTANCE = 8'd4;
  localparam logic [CH_W-1:0]  WEIGHT_BASE  = 8'd5;
  localparam logic signed [7:0] RSSI_FLOOR  = -8'sd100;
  localparam logic signed [7:0] RSSI_CEIL   = -8'sd30;
  localparam logic signed [7:0] RSSI_OFFSET = 8'sd101;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_SELECT
  } wcis_state_e;

  typedef struct packed {
    logic load;
    logic accum;
    logic select;
  } wcis_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } wcis_sts_t;

  function automatic logic [WGT_W-1:0] weight_of(input logic [OUT_W-1:0] cand,
                                                 input logic [CH_W-1:0]  ch);
    logic [CH_W-1:0] cand_x;
    logic [CH_W-1:0] span;
    cand_x = CH_W'(cand);
    span   = (cand_x > ch) ? (cand_x - ch) : (ch - cand_x);
    if (span <= MAX_DISTANCE) begin
      weight_of = WGT_W'(WEIGHT_BASE - span);
    end else begin
      weight_of = '0;
    end
  endfunction

  function automatic logic [IDX_W-1:0] fallback_idx(input logic [CH_W-1:0] pref);
    fallback_idx = '0;
    for (int unsigned i = 0; i < NUM_CAND; i++) begin
      if (CH_W'(CAND_CH[i]) == pref) begin
        fallback_idx = IDX_W'(i);
      end
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/wifi_channel_interference_select.sv
// Top level of the interference-based Wi-Fi channel selector.
// For each scan observation, the accept cycle clamps the signal level and squares the
// strength, and the next cycle adds the weighted square to the scores for channels 1, 6
// and 11; no new observation is taken while the last one is being added. After an
// observation marked last, the select state compares the three scores, places the winner
// in the output register and clears the scores. The select state waits while the output
// register still holds a result that has not been taken; a new observation may be
// accepted while a result waits there. The preferred channel register may be written at any
// cycle and is meant to change only between scans.
`default_nettype none
module wifi_channel_interference_select (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [wcis_pkg::CH_W-1:0] scan_channel_i,
  input  wire logic signed [7:0]         signal_dbm_i,
  input  wire logic                      last_item_i,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [wcis_pkg::CH_W-1:0] preferred_channel_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [wcis_pkg::OUT_W-1:0]     chosen_channel_o
);

  wcis_pkg::wcis_cmd_t cmd;
  wcis_pkg::wcis_sts_t sts;

  assign cfg_ready_o = 1'b1;

  wcis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wcis_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .scan_channel_i      (scan_channel_i),
    .signal_dbm_i        (signal_dbm_i),
    .last_item_i         (last_item_i),
    .cfg_valid_i         (cfg_valid_i),
    .preferred_channel_i (preferred_channel_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .chosen_channel_o    (chosen_channel_o)
  );

`include "wifi_channel_interference_select_assert.svh"

  `WCIS_ASSERT(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o, "Accepted transaction did not hold off the next one")
  `WCIS_ASSERT(a_result_after_work, $rose(out_valid_o) |-> $past(in_stall_o), "Result appeared without a transaction in work")
  `WCIS_ASSERT(a_chosen_is_candidate, out_valid_o |-> (chosen_channel_o == wcis_pkg::CAND_CH[0] || chosen_channel_o == wcis_pkg::CAND_CH[1] || chosen_channel_o == wcis_pkg::CAND_CH[2]), "Chosen channel is not a candidate")
  `WCIS_ASSERT_ALWAYS(a_reset_no_result, !rst_ni |-> !out_valid_o, "Result valid during reset")

endmodule
`default_nettype wire

FILE: rtl/core/wcis_ctrl.sv
// Controller state machine sequencing load, accumulate and selection steps.
`default_nettype none
module wcis_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire wcis_pkg::wcis_sts_t sts_i,
  output wcis_pkg::wcis_cmd_t    cmd_o
);

  wcis_pkg::wcis_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wcis_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      wcis_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = wcis_pkg::ST_ACCUM;
        end
      end
      wcis_pkg::ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        state_d     = sts_i.last ? wcis_pkg::ST_SELECT : wcis_pkg::ST_IDLE;
      end
      wcis_pkg::ST_SELECT: begin
        if (sts_i.out_free) begin
          cmd_o.select = 1'b1;
          state_d      = wcis_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wcis_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/wcis_dp.sv
// Datapath holding the squared strength, the three scores and the output register.
`default_nettype none
module wcis_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire wcis_pkg::wcis_cmd_t         cmd_i,
  output wcis_pkg::wcis_sts_t              sts_o,
  input  wire logic [wcis_pkg::CH_W-1:0]   scan_channel_i,
  input  wire logic signed [7:0]           signal_dbm_i,
  input  wire logic                        last_item_i,
  input  wire logic                        cfg_valid_i,
  input  wire logic [wcis_pkg::CH_W-1:0]   preferred_channel_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [wcis_pkg::OUT_W-1:0]       chosen_channel_o
);

  logic [wcis_pkg::CH_W-1:0]    pref_q;
  logic [wcis_pkg::SQ_W-1:0]    sq_q, sq_d;
  logic [wcis_pkg::WGT_W-1:0]   w_q [wcis_pkg::NUM_CAND];
  logic [wcis_pkg::WGT_W-1:0]   w_d [wcis_pkg::NUM_CAND];
  logic                         last_q;
  logic [wcis_pkg::SCORE_W-1:0] score_q [wcis_pkg::NUM_CAND];
  logic [wcis_pkg::PROD_W-1:0]  prod [wcis_pkg::NUM_CAND];
  logic                         out_valid_q;
  logic [wcis_pkg::OUT_W-1:0]   chosen_q, chosen_d;

  logic signed [7:0]            rssi_c;
  logic signed [7:0]            str_s;
  logic [wcis_pkg::STR_W-1:0]   str;
  logic [2*wcis_pkg::STR_W-1:0] sq_full;
  logic                         ch_ok;
  logic [wcis_pkg::NUM_CAND-1:0] is_min;
  logic [wcis_pkg::IDX_W-1:0]   fb_idx;
  logic                         out_free;

  always_comb begin
    priority if (signal_dbm_i < wcis_pkg::RSSI_FLOOR) begin
      rssi_c = wcis_pkg::RSSI_FLOOR;
    end else if (signal_dbm_i > wcis_pkg::RSSI_CEIL) begin
      rssi_c = wcis_pkg::RSSI_CEIL;
    end else begin
      rssi_c = signal_dbm_i;
    end
    str_s   = rssi_c + wcis_pkg::RSSI_OFFSET;
    str     = str_s[wcis_pkg::STR_W-1:0];
    sq_full = str * str;
    sq_d    = sq_full[wcis_pkg::SQ_W-1:0];
    ch_ok   = (scan_channel_i >= wcis_pkg::CH_W'(1)) &&
              (scan_channel_i <= wcis_pkg::MAX_CHANNEL);
    for (int unsigned i = 0; i < wcis_pkg::NUM_CAND; i++) begin
      w_d[i] = ch_ok ? wcis_pkg::weight_of(wcis_pkg::CAND_CH[i], scan_channel_i) : '0;
    end
  end

  always_comb begin
    for (int unsigned i = 0; i < wcis_pkg::NUM_CAND; i++) begin
      prod[i] = wcis_pkg::PROD_W'(sq_q) * wcis_pkg::PROD_W'(w_q[i]);
    end
  end

  // A candidate is a minimum when no other score is strictly below it.
  always_comb begin
    is_min[0] = !(score_q[1] < score_q[0]) && !(score_q[2] < score_q[0]);
    is_min[1] = !(score_q[0] < score_q[1]) && !(score_q[2] < score_q[1]);
    is_min[2] = !(score_q[0] < score_q[2]) && !(score_q[1] < score_q[2]);
    fb_idx    = wcis_pkg::fallback_idx(pref_q);
    priority if (is_min[fb_idx]) begin
      chosen_d = wcis_pkg::CAND_CH[fb_idx];
    end else if (is_min[0]) begin
      chosen_d = wcis_pkg::CAND_CH[0];
    end else if (is_min[1]) begin
      chosen_d = wcis_pkg::CAND_CH[1];
    end else begin
      chosen_d = wcis_pkg::CAND_CH[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sq_q   <= sq_d;
      w_q    <= w_d;
      last_q <= last_item_i;
    end
    if (cmd_i.select) begin
      chosen_q <= chosen_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pref_q <= wcis_pkg::PREF_RESET;
    end else if (cfg_valid_i) begin
      pref_q <= preferred_channel_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < wcis_pkg::NUM_CAND; i++) begin
        score_q[i] <= '0;
      end
    end else if (cmd_i.select) begin
      for (int unsigned i = 0; i < wcis_pkg::NUM_CAND; i++) begin
        score_q[i] <= '0;
      end
    end else if (cmd_i.accum) begin
      for (int unsigned i = 0; i < wcis_pkg::NUM_CAND; i++) begin
        score_q[i] <= score_q[i] + wcis_pkg::SCORE_W'(prod[i]);
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.select) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.last       = last_q;
  assign sts_o.out_free   = out_free;
  assign out_valid_o      = out_valid_q;
  assign chosen_channel_o = chosen_q;

endmodule
`default_nettype wire

FILE: tb/wifi_channel_interference_select_tb.sv
// Self-checking testbench for the interference-based Wi-Fi channel selector.
`timescale 1ns / 100ps

module wifi_channel_interference_select_tb;

  localparam int unsigned NUM_CANDIDATES = 3;
  localparam logic [3:0]  CANDIDATE_CH [NUM_CANDIDATES] = '{4'd1, 4'd6, 4'd11};
  localparam logic [3:0]  DEFAULT_FALLBACK = 4'd1;
  localparam int          LOWEST_CHANNEL = 1;
  localparam int          HIGHEST_CHANNEL = 14;
  localparam int          DBM_FLOOR = -100;
  localparam int          DBM_CEIL = -30;
  localparam int          STRENGTH_OFFSET = 101;
  localparam int          OVERLAP_REACH = 4;
  localparam int          OVERLAP_BASE = 5;
  localparam int unsigned MAX_GAP = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned RANDOM_ITEMS = 800;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        scan_channel;
  logic signed [7:0] signal_dbm;
  logic              last_item;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [7:0]        preferred_channel;
  logic              out_valid;
  logic              out_stall;
  logic [3:0]        chosen_channel;

  logic [63:0]       model_scores [NUM_CANDIDATES];
  logic [7:0]        model_preferred;
  logic [3:0]        chosen_expected [$];
  logic [3:0]        oldest_choice;

  bit                sender_idles;
  bit                receiver_idles;
  bit                hold_request;
  int unsigned       idle_cycles;
  int                mismatches;
  int                obs_accepted;
  int                scans_closed;
  int                results_seen;
  int                cfg_writes;
  int                hold_offs;

  wifi_channel_interference_select dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .scan_channel_i     (scan_channel),
    .signal_dbm_i       (signal_dbm),
    .last_item_i        (last_item),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .preferred_channel_i(preferred_channel),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .chosen_channel_o   (chosen_channel)
  );

  always #5 clk = ~clk;

  function automatic int unsigned draw_gap(input bit enabled);
    if (!enabled || $urandom_range(3, 0) == 0) begin
      return 0;
    end
    return $urandom_range(MAX_GAP, 0);
  endfunction

  task automatic report_mismatch(input string what, input int expected, input int actual);
    $display("MISMATCH %s: expected %0d, got %0d at %0t", what, expected, actual, $realtime);
    mismatches++;
  endtask

  // Adds one observation to the interference scores and, on the closing item of a
  // scan, works out the channel that the block must choose.
  task automatic fold_observation(input logic [7:0] ch, input logic signed [7:0] dbm,
                                  input logic last);
    int          level;
    int          span;
    int          weight;
    logic [63:0] strength_sq;
    logic [63:0] lowest;
    logic [3:0]  fallback;
    logic [3:0]  pick;
    bit          fallback_ties;
    bit          found;
    level = dbm;
    if (ch >= LOWEST_CHANNEL && ch <= HIGHEST_CHANNEL) begin
      if (level < DBM_FLOOR) begin
        level = DBM_FLOOR;
      end else if (level > DBM_CEIL) begin
        level = DBM_CEIL;
      end
      strength_sq = 64'(level + STRENGTH_OFFSET) * 64'(level + STRENGTH_OFFSET);
      for (int i = 0; i < NUM_CANDIDATES; i++) begin
        span = (int'(CANDIDATE_CH[i]) > int'(ch)) ? int'(CANDIDATE_CH[i]) - int'(ch)
                                                  : int'(ch) - int'(CANDIDATE_CH[i]);
        weight = (span <= OVERLAP_REACH) ? OVERLAP_BASE - span : 0;
        model_scores[i] = model_scores[i] + strength_sq * 64'(weight);
      end
    end
    if (last) begin
      fallback = DEFAULT_FALLBACK;
      for (int i = 0; i < NUM_CANDIDATES; i++) begin
        if (8'(CANDIDATE_CH[i]) == model_preferred) begin
          fallback = CANDIDATE_CH[i];
        end
      end
      lowest = model_scores[0];
      for (int i = 1; i < NUM_CANDIDATES; i++) begin
        if (model_scores[i] < lowest) begin
          lowest = model_scores[i];
        end
      end
      fallback_ties = 1'b0;
      for (int i = 0; i < NUM_CANDIDATES; i++) begin
        if (CANDIDATE_CH[i] == fallback && model_scores[i] == lowest) begin
          fallback_ties = 1'b1;
        end
      end
      pick = fallback;
      found = fallback_ties;
      for (int i = 0; i < NUM_CANDIDATES; i++) begin
        if (!found && model_scores[i] == lowest) begin
          pick = CANDIDATE_CH[i];
          found = 1'b1;
        end
      end
      chosen_expected.push_back(pick);
      for (int i = 0; i < NUM_CANDIDATES; i++) begin
        model_scores[i] = '0;
      end
      scans_closed++;
    end
  endtask

  task automatic send_observation(input logic [7:0] ch, input logic signed [7:0] dbm,
                                  input logic last);
    int unsigned gap;
    gap = draw_gap(sender_idles);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    scan_channel <= ch;
    signal_dbm   <= dbm;
    last_item    <= last;
    do @(posedge clk); while (in_stall);
    fold_observation(ch, dbm, last);
    obs_accepted++;
  endtask

  // The register is only written between scans, once the block has gone quiet.
  task automatic write_preferred(input logic [7:0] value);
    in_valid <= 1'b0;
    while (chosen_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid         <= 1'b1;
    preferred_channel <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_preferred = value;
    cfg_writes++;
  endtask

  task automatic test_reset_preference;
    send_observation(8'd0, -8'sd60, 1'b1);
    send_observation(8'd255, 8'sd0, 1'b1);
  endtask

  task automatic test_field_extremes;
    send_observation(8'd1, -8'sd128, 1'b0);
    send_observation(8'd14, 8'sd127, 1'b0);
    send_observation(8'd15, -8'sd50, 1'b0);
    send_observation(8'd128, 8'sd0, 1'b0);
    send_observation(8'd7, -8'sd100, 1'b0);
    send_observation(8'd13, -8'sd101, 1'b0);
    send_observation(8'd2, -8'sd30, 1'b0);
    send_observation(8'd3, -8'sd29, 1'b0);
    send_observation(8'd255, -8'sd1, 1'b1);
    send_observation(8'd11, -8'sd60, 1'b1);
  endtask

  task automatic test_tie_breaking;
    write_preferred(8'd11);
    send_observation(8'd6, -8'sd70, 1'b1);
    write_preferred(8'd6);
    send_observation(8'd1, -8'sd45, 1'b1);
    write_preferred(8'd0);
    send_observation(8'd1, -8'sd45, 1'b1);
    write_preferred(8'd255);
    send_observation(8'd200, -8'sd45, 1'b1);
    write_preferred(8'd7);
    send_observation(8'd11, -8'sd80, 1'b1);
    write_preferred(8'd1);
    send_observation(8'd6, -8'sd70, 1'b1);
  endtask

  task automatic test_output_backpressure;
    logic signed [7:0] dbm;
    sender_idles = 1'b0;
    @(posedge clk);
    hold_request = 1'b1;
    for (int k = 0; k < 30; k++) begin
      dbm = 8'(int'($urandom_range(70, 0)) + DBM_FLOOR);
      send_observation(8'($urandom_range(HIGHEST_CHANNEL, LOWEST_CHANNEL)), dbm, k % 3 == 2);
    end
    sender_idles = 1'b1;
  endtask

  task automatic test_random_scans;
    logic [7:0]        settings [6];
    logic [7:0]        ch;
    logic signed [7:0] dbm;
    int unsigned       scan_len;
    int unsigned       roll;
    int                counted;
    int                phase_target;
    settings = '{8'd0, 8'd6, 8'd255, 8'd11, 8'd0, 8'd1};
    settings[4] = 8'($urandom_range(255, 0));
    counted = 0;
    for (int phase = 0; phase < 6; phase++) begin
      write_preferred(settings[phase]);
      phase_target = (phase + 1) * RANDOM_ITEMS / 6;
      while (counted < phase_target) begin
        if ($urandom_range(15, 0) == 0) begin
          sender_idles = !sender_idles;
        end
        if ($urandom_range(15, 0) == 0) begin
          receiver_idles = !receiver_idles;
        end
        if ($urandom_range(15, 0) == 0) begin
          ch = $urandom_range(1, 0) ? 8'd0 : 8'($urandom_range(255, HIGHEST_CHANNEL + 1));
          send_observation(ch, 8'($urandom_range(255, 0)), 1'b1);
          counted++;
        end else begin
          scan_len = $urandom_range(12, 1);
          for (int unsigned k = 0; k < scan_len; k++) begin
            roll = $urandom_range(9, 0);
            if (roll < 8) begin
              ch = 8'($urandom_range(HIGHEST_CHANNEL, LOWEST_CHANNEL));
            end else if (roll == 8) begin
              ch = $urandom_range(1, 0) ? 8'd0
                                         : 8'($urandom_range(255, HIGHEST_CHANNEL + 1));
            end else begin
              ch = 8'($urandom_range(255, 0));
            end
            if ($urandom_range(9, 0) < 7) begin
              dbm = 8'(int'($urandom_range(70, 0)) + DBM_FLOOR);
            end else begin
              dbm = 8'($urandom_range(255, 0));
            end
            send_observation(ch, dbm, k == scan_len - 1);
            counted++;
          end
        end
      end
    end
  endtask

  initial begin : receiver
    int unsigned wait_cycles;
    out_stall <= 1'b0;
    forever begin
      do @(posedge clk); while (!(out_valid && !out_stall) && !hold_request);
      if (hold_request) begin
        hold_request = 1'b0;
        wait_cycles = HOLD_OFF_CYCLES;
        hold_offs++;
      end else begin
        wait_cycles = draw_gap(receiver_idles);
      end
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (chosen_expected.size() == 0) begin
        report_mismatch("chosen_channel with no scan pending", -1, chosen_channel);
      end else begin
        oldest_choice = chosen_expected.pop_front();
        if (chosen_channel !== oldest_choice) begin
          report_mismatch("chosen_channel", oldest_choice, chosen_channel);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired after %0d cycles without a transaction", idle_cycles);
        $display("wifi_channel_interference_select_tb failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    scan_channel <= '0;
    signal_dbm <= '0;
    last_item <= 1'b0;
    cfg_valid <= 1'b0;
    preferred_channel <= '0;
    idle_cycles <= 0;
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    hold_request = 1'b0;
    model_preferred = 8'd1;
    for (int i = 0; i < NUM_CANDIDATES; i++) begin
      model_scores[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_preference();
    test_field_extremes();
    test_tie_breaking();
    test_output_backpressure();
    test_random_scans();

    in_valid <= 1'b0;
    while (chosen_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d observations in %0d scans, %0d choices checked, %0d mismatches.",
             obs_accepted, scans_closed, results_seen, mismatches);
    $display("Preferred channel written %0d times; output held off %0d times.",
             cfg_writes, hold_offs);
    if (mismatches == 0) begin
      $display("wifi_channel_interference_select_tb passed");
    end else begin
      $display("wifi_channel_interference_select_tb failed");
    end
    $finish;
  end

endmodule
